>>> sv/json_token_lexer_unit_macros.svh
// Assertion macros used by the lexer checker.
`ifndef JSON_TOKEN_LEXER_UNIT_MACROS_SVH
`define JSON_TOKEN_LEXER_UNIT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define JTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also checks across reset.
`define JTL_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/jtl_pkg.sv
// Shared constants and types of the JSON token lexer.
package jtl_pkg;

  localparam int POS_BITS = 32;
  localparam int LEN_BITS = 12;
  localparam int MAX_LEN  = 4095;

  localparam logic [3:0] KIND_INVALID   = 4'd0;
  localparam logic [3:0] KIND_OBJ_BEGIN = 4'd1;
  localparam logic [3:0] KIND_OBJ_END   = 4'd2;
  localparam logic [3:0] KIND_ARR_BEGIN = 4'd3;
  localparam logic [3:0] KIND_ARR_END   = 4'd4;
  localparam logic [3:0] KIND_COLON     = 4'd5;
  localparam logic [3:0] KIND_COMMA     = 4'd6;
  localparam logic [3:0] KIND_STRING    = 4'd7;
  localparam logic [3:0] KIND_NUMBER    = 4'd8;

  typedef struct packed {
    logic [3:0]          kind;
    logic [POS_BITS-1:0] start;
    logic [LEN_BITS-1:0] length;
    logic                clipped;
    logic                last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t1;
    tok_t       t0;
  } tok_pair_t;

endpackage

>>> sv/jtl_char_if.sv
// Character input channel.
interface jtl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, char_in, end_of_text, input ready);
  modport sink (input valid, char_in, end_of_text, output ready);
endinterface

>>> sv/jtl_token_if.sv
// Token output channel.
interface jtl_token_if import jtl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [3:0]          token_kind;
  logic [POS_BITS-1:0] token_start;
  logic [LEN_BITS-1:0] token_length;
  logic                length_clipped;
  logic                last_of_run;

  modport source (output valid, token_kind, token_start, token_length, length_clipped,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, token_start, token_length, length_clipped,
                last_of_run, output ready);
endinterface

>>> sv/jtl_lexer_core.sv
// Lexer state and per-character token logic.
module jtl_lexer_core import jtl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_in,
  input  logic       end_of_text,
  output tok_pair_t  toks
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_MINUS = 3'd1;
  localparam logic [2:0] PH_INT   = 3'd2;
  localparam logic [2:0] PH_DOT   = 3'd3;
  localparam logic [2:0] PH_FRAC  = 3'd4;
  localparam logic [2:0] PH_EXP   = 3'd5;
  localparam logic [2:0] PH_ESIGN = 3'd6;
  localparam logic [2:0] PH_EDIG  = 3'd7;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  logic [1:0]          mode, mode_next;
  logic [2:0]          phase, phase_next;
  logic [LEN_BITS-1:0] len, len_next;
  logic                clip, clip_next;
  logic [POS_BITS-1:0] start, start_next;
  logic [POS_BITS-1:0] pos, pos_next;

  // {moved, next phase}; moved low means no transition
  function automatic logic [3:0] num_next(logic [2:0] ph, logic [7:0] c);
    logic dig;
    dig = (c >= CH_0) && (c <= CH_9);
    if (dig) begin
      unique case (ph)
        PH_START, PH_MINUS, PH_INT: return {1'b1, PH_INT};
        PH_DOT, PH_FRAC:            return {1'b1, PH_FRAC};
        default:                    return {1'b1, PH_EDIG};
      endcase
    end
    if (c == CH_E && (ph == PH_INT || ph == PH_FRAC)) return {1'b1, PH_EXP};
    if (c == CH_DOT && ph == PH_INT) return {1'b1, PH_DOT};
    if ((c == CH_MINUS || c == CH_PLUS) && ph == PH_EXP) return {1'b1, PH_ESIGN};
    if (c == CH_MINUS && ph == PH_START) return {1'b1, PH_MINUS};
    return 4'd0;
  endfunction

  function automatic logic [3:0] judged(logic [2:0] ph);
    return (ph == PH_INT || ph == PH_FRAC || ph == PH_EDIG) ? KIND_NUMBER : KIND_INVALID;
  endfunction

  function automatic tok_pair_t push(tok_pair_t p, logic [3:0] k, logic [POS_BITS-1:0] s,
                                     logic [LEN_BITS-1:0] l, logic cl);
    tok_t t;
    t = '{kind: k, start: s, length: l, clipped: cl, last: 1'b0};
    if (p.cnt == 2'd0) p.t0 = t;
    else p.t1 = t;
    p.cnt = p.cnt + 2'd1;
    return p;
  endfunction

  logic                is_digit, is_delim, is_skip, is_single, at_max, do_idle;
  logic [3:0]          single_kind, nx;
  logic [LEN_BITS-1:0] grown_len;
  logic                grown_clip;
  tok_pair_t           p;

  always_comb begin
    is_digit = (char_in >= CH_0) && (char_in <= CH_9);
    is_delim = (char_in == CH_COMMA) || (char_in == CH_RBRACE) || (char_in == CH_RBRACK);
    is_skip  = (char_in == CH_SPACE) || (char_in == CH_LF) || (char_in == CH_T) ||
               (char_in == CH_F) || (char_in == CH_N);
    is_single = 1'b1;
    unique case (char_in)
      CH_LBRACE: single_kind = KIND_OBJ_BEGIN;
      CH_RBRACE: single_kind = KIND_OBJ_END;
      CH_LBRACK: single_kind = KIND_ARR_BEGIN;
      CH_RBRACK: single_kind = KIND_ARR_END;
      CH_COLON:  single_kind = KIND_COLON;
      CH_COMMA:  single_kind = KIND_COMMA;
      default: begin
        single_kind = KIND_INVALID;
        is_single   = 1'b0;
      end
    endcase
  end

  always_comb begin
    at_max     = len >= LEN_BITS'(MAX_LEN);
    grown_len  = at_max ? len : len + LEN_BITS'(1);
    grown_clip = clip | at_max;
    p          = '0;
    mode_next  = mode;
    phase_next = phase;
    len_next   = len;
    clip_next  = clip;
    start_next = start;
    pos_next   = pos + POS_BITS'(1);
    do_idle    = 1'b0;
    nx         = num_next(phase, char_in);

    unique case (mode)
      MODE_STR: begin
        len_next  = grown_len;
        clip_next = grown_clip;
        if (char_in == CH_QUOTE) begin
          p         = push(p, KIND_STRING, start, grown_len, grown_clip);
          mode_next = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (is_delim) begin
          p          = push(p, judged(phase), start, len, clip);
          mode_next  = MODE_IDLE;
          phase_next = PH_START;
          do_idle    = 1'b1;
        end else begin
          len_next  = grown_len;
          clip_next = grown_clip;
          if (!nx[3]) begin
            p          = push(p, KIND_INVALID, start, grown_len, grown_clip);
            mode_next  = MODE_IDLE;
            phase_next = PH_START;
          end else begin
            phase_next = nx[2:0];
          end
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        do_idle   = 1'b1;
      end
    endcase

    if (do_idle) begin
      priority if (is_single) begin
        p = push(p, single_kind, pos, LEN_BITS'(1), 1'b0);
      end else if (char_in == CH_QUOTE) begin
        mode_next  = MODE_STR;
        start_next = pos;
        len_next   = LEN_BITS'(1);
        clip_next  = 1'b0;
      end else if (is_digit || char_in == CH_MINUS) begin
        mode_next  = MODE_NUM;
        start_next = pos;
        len_next   = LEN_BITS'(1);
        clip_next  = 1'b0;
        phase_next = is_digit ? PH_INT : PH_MINUS;
      end else begin
        if (!is_skip) p = push(p, KIND_INVALID, pos, LEN_BITS'(1), 1'b0);
      end
    end

    if (end_of_text) begin
      if (mode_next == MODE_STR) begin
        p = push(p, KIND_INVALID, start_next, len_next, clip_next);
      end else if (mode_next == MODE_NUM) begin
        p = push(p, judged(phase_next), start_next, len_next, clip_next);
      end
      mode_next  = MODE_IDLE;
      phase_next = PH_START;
      pos_next   = '0;
    end

    if (p.cnt == 2'd1) p.t0.last = 1'b1;
    if (p.cnt == 2'd2) p.t1.last = 1'b1;
    toks = p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      phase <= PH_START;
      len   <= '0;
      clip  <= 1'b0;
      start <= '0;
      pos   <= '0;
    end else if (step) begin
      mode  <= mode_next;
      phase <= phase_next;
      len   <= len_next;
      clip  <= clip_next;
      start <= start_next;
      pos   <= pos_next;
    end
  end

endmodule

>>> sv/jtl_token_fifo.sv
// Four-entry token queue, up to two writes and one read per cycle.
module jtl_token_fifo import jtl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tok_pair_t wr,
  output logic      room,
  input  logic      pop,
  output logic      head_valid,
  output tok_t      head
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count, count_next;
  logic [1:0]    n_in;
  logic          do_pop;

  assign n_in       = push ? wr.cnt : 2'd0;
  assign do_pop     = pop && head_valid;
  assign head_valid = count != '0;
  assign head       = mem[rp];
  assign room       = count <= (AW+1)'(DEPTH - 2);
  assign count_next = count + (AW+1)'(n_in) - (AW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) mem[wp] <= wr.t0;
    if (n_in == 2'd2) mem[wp + AW'(1)] <= wr.t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + AW'(n_in);
      rp    <= rp + AW'(do_pop);
      count <= count_next;
    end
  end

endmodule

>>> sv/json_token_lexer_unit.sv
// Top level of the JSON token lexer.
//   channel  dir  transaction
//   chars    in   one text byte plus end-of-text mark
//   tokens   out  kind, start, length, clip flag, last-of-run flag
// A byte is registered on entry and lexed once the queue has room; its tokens are then written to the queue.
// Sustained rate is one byte per cycle; input stalls while three or more tokens are queued,
// which takes bytes that yield two tokens or an output slower than the input.
// Synchronous reset returns the lexer to idle at position zero and empties the queue.
// Output stalls back up through the queue into the input register.
module json_token_lexer_unit import jtl_pkg::*; (
  input logic        clk,
  input logic        rst,
  jtl_char_if.sink   chars,
  jtl_token_if.source tokens
);

  logic       in_valid;
  logic [7:0] char_q;
  logic       eot_q;
  logic       room;
  logic       step;
  tok_pair_t  toks;
  tok_t       head;
  logic       head_valid;

  assign step        = in_valid && room;
  assign chars.ready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      char_q <= chars.char_in;
      eot_q  <= chars.end_of_text;
    end
  end

  jtl_lexer_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .char_in     (char_q),
    .end_of_text (eot_q),
    .toks        (toks)
  );

  jtl_token_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .wr         (toks),
    .room       (room),
    .pop        (tokens.ready),
    .head_valid (head_valid),
    .head       (head)
  );

  assign tokens.valid          = head_valid;
  assign tokens.token_kind     = head.kind;
  assign tokens.token_start    = head.start;
  assign tokens.token_length   = head.length;
  assign tokens.length_clipped = head.clipped;
  assign tokens.last_of_run    = head.last;

endmodule

>>> sv/jtl_checker.sv
// Port-level checks for the JSON token lexer, bound to the top level.
`include "json_token_lexer_unit_macros.svh"

module jtl_checker import jtl_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                tok_valid,
  input logic                tok_ready,
  input logic [3:0]          kind,
  input logic [POS_BITS-1:0] start,
  input logic [LEN_BITS-1:0] length,
  input logic                clipped,
  input logic                last
);

  logic                         stalled;
  logic                         punct;
  logic                         single_ok;
  logic [POS_BITS+LEN_BITS+5:0] tok_bits;

  assign stalled   = tok_valid && !tok_ready;
  assign punct     = (kind == KIND_OBJ_BEGIN) || (kind == KIND_OBJ_END) ||
                     (kind == KIND_ARR_BEGIN) || (kind == KIND_ARR_END) ||
                     (kind == KIND_COLON) || (kind == KIND_COMMA);
  assign single_ok = (length == LEN_BITS'(1)) && !clipped;
  assign tok_bits  = {kind, start, length, clipped, last};

  `JTL_ASSERT(a_tok_hold, stalled |=> tok_valid && $stable(tok_bits), "token changed while stalled")
  `JTL_ASSERT(a_single_len, tok_valid && punct |-> single_ok, "punctuation token too long")
  `JTL_ASSERT(a_clip_max, tok_valid && clipped |-> length == LEN_BITS'(MAX_LEN), "clip below max")
  `JTL_ASSERT(a_kind_len, tok_valid |-> kind <= KIND_NUMBER && length != '0, "bad kind or length")
  `JTL_ASSERT_RST(a_reset_empty, rst |=> !tok_valid, "token present after reset")

endmodule

bind json_token_lexer_unit jtl_checker u_jtl_checker (
  .clk       (clk),
  .rst       (rst),
  .tok_valid (tokens.valid),
  .tok_ready (tokens.ready),
  .kind      (tokens.token_kind),
  .start     (tokens.token_start),
  .length    (tokens.token_length),
  .clipped   (tokens.length_clipped),
  .last      (tokens.last_of_run)
);
